[design/multi_queue_event_router_unit_macros.svh]
// Assertion shorthands for the event router checker.
// Both expect clk and arst_n in the scope where they are used.
`ifndef MULTI_QUEUE_EVENT_ROUTER_UNIT_MACROS_SVH
`define MULTI_QUEUE_EVENT_ROUTER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MQER_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mqer: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define MQER_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mqer: next-cycle check failed");

`endif

[design/mqer_pkg.sv]
`default_nettype none

package mqer_pkg;

	localparam int QUEUE_DEPTH_DEF  = 16;
	localparam int SOURCE_COUNT_DEF = 6;
	localparam int PAYLOAD_BITS_DEF = 32;

	localparam int CMD_W  = 2;
	localparam int TYPE_W = 3;
	localparam int SRC_W  = 3;

	// request commands
	localparam logic [CMD_W-1:0] CMD_SCHED = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DEQ   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_DRAIN = 2'd2;

	// event types with a fixed meaning; 1..SOURCE_COUNT select a source queue
	localparam logic [TYPE_W-1:0] TYPE_NONE = 3'd0;
	localparam logic [TYPE_W-1:0] TYPE_MAIN = 3'd7;

	// controller to datapath
	typedef struct packed {
		logic load_item;   // capture the accepted request
		logic push_sched;  // route the captured event to its queue
		logic deq_read;    // read head of main queue, advance its read pointer
		logic deq_none;    // present an empty-queue result
		logic deq_load;    // present the main queue read data
		logic drain_issue; // read head of the source queue, advance its read pointer
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic main_empty;
		logic src_ok;      // captured source index names a real queue
		logic src_empty;
		logic drain_pend;  // a source read is still on its way to the main queue
		logic out_free;    // result register can take a new result this cycle
	} dp_stat_t;

endpackage

`default_nettype wire

[design/mqer_ctrl.sv]
`default_nettype none

module mqer_ctrl (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	input  wire logic [mqer_pkg::CMD_W-1:0] in_cmd,
	output logic                            in_ready,
	input  wire mqer_pkg::dp_stat_t         stat,
	output mqer_pkg::ctrl_cmd_t             cmd
);
	import mqer_pkg::*;

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_SCHED    = 3'd1;
	localparam logic [2:0] ST_DEQ      = 3'd2;
	localparam logic [2:0] ST_DEQ_WAIT = 3'd3;
	localparam logic [2:0] ST_DRAIN    = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_item = 1'b1;
					unique case (in_cmd)
						CMD_SCHED: state_d = ST_SCHED;
						CMD_DEQ:   state_d = ST_DEQ;
						CMD_DRAIN: state_d = ST_DRAIN;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_SCHED: begin
				cmd.push_sched = 1'b1;
				state_d        = ST_IDLE;
			end
			ST_DEQ: begin
				// hold until the result register is free
				if (stat.out_free) begin
					if (stat.main_empty) begin
						cmd.deq_none = 1'b1;
						state_d      = ST_IDLE;
					end else begin
						cmd.deq_read = 1'b1;
						state_d      = ST_DEQ_WAIT;
					end
				end
			end
			ST_DEQ_WAIT: begin
				cmd.deq_load = 1'b1;
				state_d      = ST_IDLE;
			end
			ST_DRAIN: begin
				if (!stat.src_ok) begin
					state_d = ST_IDLE;
				end else begin
					cmd.drain_issue = !stat.src_empty;
					if (stat.src_empty && !stat.drain_pend) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

[design/mqer_dp.sv]
`default_nettype none

module mqer_dp #(
	parameter int QUEUE_DEPTH  = mqer_pkg::QUEUE_DEPTH_DEF,
	parameter int SOURCE_COUNT = mqer_pkg::SOURCE_COUNT_DEF,
	parameter int PAYLOAD_BITS = mqer_pkg::PAYLOAD_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire mqer_pkg::ctrl_cmd_t         cmd,
	output mqer_pkg::dp_stat_t               stat,
	input  wire logic [mqer_pkg::TYPE_W-1:0] in_type,
	input  wire logic [PAYLOAD_BITS-1:0]     in_payload,
	input  wire logic [mqer_pkg::SRC_W-1:0]  in_source,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [mqer_pkg::TYPE_W-1:0]      out_type,
	output logic [PAYLOAD_BITS-1:0]          out_payload
);
	import mqer_pkg::*;

	localparam int PTR_W  = $clog2(QUEUE_DEPTH);
	localparam int QSEL_W = $clog2(SOURCE_COUNT + 1);
	localparam int SRC_N  = SOURCE_COUNT * QUEUE_DEPTH;
	localparam int SRC_AW = $clog2(SRC_N);
	localparam int REC_W  = TYPE_W + PAYLOAD_BITS;

	localparam logic [QSEL_W-1:0] MAIN_Q   = QSEL_W'(SOURCE_COUNT);
	localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

	typedef logic [REC_W-1:0] rec_t;

	// captured request
	logic [TYPE_W-1:0]       type_q;
	logic [PAYLOAD_BITS-1:0] payload_q;
	logic [SRC_W-1:0]        source_q;

	// ring pointers; the last entry belongs to the main queue
	logic [PTR_W-1:0] rd_ptr_q [SOURCE_COUNT+1];
	logic [PTR_W-1:0] wr_ptr_q [SOURCE_COUNT+1];

	rec_t src_mem  [SRC_N];
	rec_t main_mem [QUEUE_DEPTH];

	rec_t src_rdata_s1;
	logic drain_vld_s1;
	rec_t main_rdata_q;

	logic                    out_valid_q;
	logic [TYPE_W-1:0]       out_type_q;
	logic [PAYLOAD_BITS-1:0] out_payload_q;

	logic              sched_ok;
	logic [QSEL_W-1:0] sched_idx;
	logic              sched_full;
	logic              src_ok;
	logic [QSEL_W-1:0] src_idx;
	logic              main_empty;
	logic              main_full;
	logic              do_push;
	logic              push_main;
	logic              push_src;
	logic              drain_wr;
	logic [SOURCE_COUNT:0] rd_inc;
	logic [SOURCE_COUNT:0] wr_inc;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_LAST) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [SRC_AW-1:0] src_addr(input logic [QSEL_W-1:0] q,
	                                               input logic [PTR_W-1:0] p);
		return SRC_AW'(q) * SRC_AW'(QUEUE_DEPTH) + SRC_AW'(p);
	endfunction

	// route by type: main type to the main queue, 1..SOURCE_COUNT to a source
	always_comb begin
		sched_ok  = 1'b0;
		sched_idx = MAIN_Q;
		if (type_q == TYPE_MAIN) begin
			sched_ok = 1'b1;
		end else if (type_q != TYPE_NONE && int'(type_q) <= SOURCE_COUNT) begin
			sched_ok  = 1'b1;
			sched_idx = QSEL_W'(type_q - 1'b1);
		end
	end

	assign src_ok     = int'(source_q) < SOURCE_COUNT;
	assign src_idx    = src_ok ? QSEL_W'(source_q) : '0;
	assign sched_full = ptr_inc(wr_ptr_q[sched_idx]) == rd_ptr_q[sched_idx];
	assign main_empty = rd_ptr_q[MAIN_Q] == wr_ptr_q[MAIN_Q];
	assign main_full  = ptr_inc(wr_ptr_q[MAIN_Q]) == rd_ptr_q[MAIN_Q];

	assign do_push   = cmd.push_sched && sched_ok && !sched_full;
	assign push_main = do_push && (sched_idx == MAIN_Q);
	assign push_src  = do_push && (sched_idx != MAIN_Q);
	// drop the drained event when the main queue is full
	assign drain_wr  = drain_vld_s1 && !main_full;

	always_comb begin
		for (int i = 0; i <= SOURCE_COUNT; i++) begin
			rd_inc[i] = (cmd.drain_issue && src_idx == QSEL_W'(i))
			         || (cmd.deq_read && MAIN_Q == QSEL_W'(i));
			wr_inc[i] = (do_push && sched_idx == QSEL_W'(i))
			         || (drain_wr && MAIN_Q == QSEL_W'(i));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= SOURCE_COUNT; i++) begin
				rd_ptr_q[i] <= '0;
				wr_ptr_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i <= SOURCE_COUNT; i++) begin
				if (rd_inc[i]) rd_ptr_q[i] <= ptr_inc(rd_ptr_q[i]);
				if (wr_inc[i]) wr_ptr_q[i] <= ptr_inc(wr_ptr_q[i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			type_q    <= in_type;
			payload_q <= in_payload;
			source_q  <= in_source;
		end
	end

	// source store: one write port (schedule), one registered read port (drain)
	always_ff @(posedge clk) begin
		if (push_src) begin
			src_mem[src_addr(sched_idx, wr_ptr_q[sched_idx])] <= {type_q, payload_q};
		end
		if (cmd.drain_issue) begin
			src_rdata_s1 <= src_mem[src_addr(src_idx, rd_ptr_q[src_idx])];
		end
	end

	// main store: write from schedule or drain, registered read for dequeue
	always_ff @(posedge clk) begin
		if (push_main) begin
			main_mem[wr_ptr_q[MAIN_Q]] <= {type_q, payload_q};
		end else if (drain_wr) begin
			main_mem[wr_ptr_q[MAIN_Q]] <= src_rdata_s1;
		end
		if (cmd.deq_read) begin
			main_rdata_q <= main_mem[rd_ptr_q[MAIN_Q]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drain_vld_s1 <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			drain_vld_s1 <= cmd.drain_issue;
			if (cmd.deq_none || cmd.deq_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.deq_none) begin
			out_type_q    <= TYPE_NONE;
			out_payload_q <= '0;
		end else if (cmd.deq_load) begin
			out_type_q    <= main_rdata_q[REC_W-1:PAYLOAD_BITS];
			out_payload_q <= main_rdata_q[PAYLOAD_BITS-1:0];
		end
	end

	assign out_valid   = out_valid_q;
	assign out_type    = out_type_q;
	assign out_payload = out_payload_q;

	always_comb begin
		stat            = '0;
		stat.main_empty = main_empty;
		stat.src_ok     = src_ok;
		stat.src_empty  = rd_ptr_q[src_idx] == wr_ptr_q[src_idx];
		stat.drain_pend = drain_vld_s1;
		stat.out_free   = !out_valid_q || out_ready;
	end

endmodule

`default_nettype wire

[design/multi_queue_event_router_unit.sv]
// Channel   Dir  tuser           tdata (low bit up)                          Meaning
// s_axis    in   command[1:0]    event_type, event_payload, interrupt_source  one request
// m_axis    out  -               out_type, out_payload                       dequeue result
//
// Schedule captures the request, then writes its queue. Dequeue waits for any earlier
// result to leave the output register, then presents an empty-queue result or reads
// the main queue and loads the result; an ignored command is only taken. Drain moves all
// source-queue events, one per cycle, to the main queue; a full main queue drops them.
// Requests are taken one at a time; s_axis_tready is high only while idle.
// arst_n clears all ring pointers; the stores themselves are not cleared.
`default_nettype none

module multi_queue_event_router_unit #(
	parameter int QUEUE_DEPTH  = mqer_pkg::QUEUE_DEPTH_DEF,
	parameter int SOURCE_COUNT = mqer_pkg::SOURCE_COUNT_DEF,
	parameter int PAYLOAD_BITS = mqer_pkg::PAYLOAD_BITS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       s_axis_tvalid,
	output logic                            s_axis_tready,
	// command
	input  wire logic [mqer_pkg::CMD_W-1:0] s_axis_tuser,
	// event_type, event_payload, interrupt_source, zero pad
	input  wire logic [((mqer_pkg::TYPE_W + PAYLOAD_BITS + mqer_pkg::SRC_W + 7) / 8) * 8 - 1:0]
	                                        s_axis_tdata,
	output logic                            m_axis_tvalid,
	input  wire logic                       m_axis_tready,
	// out_type, out_payload, zero pad
	output logic [((mqer_pkg::TYPE_W + PAYLOAD_BITS + 7) / 8) * 8 - 1:0]
	                                        m_axis_tdata
);
	import mqer_pkg::*;

	localparam int IN_W     = TYPE_W + PAYLOAD_BITS + SRC_W;
	localparam int OUT_W    = TYPE_W + PAYLOAD_BITS;
	localparam int OUT_TD_W = ((OUT_W + 7) / 8) * 8;

	ctrl_cmd_t               cmd;
	dp_stat_t                stat;
	logic [TYPE_W-1:0]       out_type;
	logic [PAYLOAD_BITS-1:0] out_payload;

	// sequencer: one request at a time, drain loop and dequeue handshake
	mqer_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_cmd   (s_axis_tuser),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// queues, pointers and the result register; pad bits of tdata are dropped here
	mqer_dp #(
		.QUEUE_DEPTH  (QUEUE_DEPTH),
		.SOURCE_COUNT (SOURCE_COUNT),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.in_type     (s_axis_tdata[TYPE_W-1:0]),
		.in_payload  (s_axis_tdata[TYPE_W+PAYLOAD_BITS-1:TYPE_W]),
		.in_source   (s_axis_tdata[IN_W-1:TYPE_W+PAYLOAD_BITS]),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_type    (out_type),
		.out_payload (out_payload)
	);

	// pack the result, zero fill to whole bytes
	assign m_axis_tdata = OUT_TD_W'({out_payload, out_type});

endmodule

`default_nettype wire

[design/mqer_checker.sv]
`default_nettype none
`include "multi_queue_event_router_unit_macros.svh"

module mqer_checker #(
	parameter int PAYLOAD_BITS = mqer_pkg::PAYLOAD_BITS_DEF
) (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       s_axis_tvalid,
	input wire logic                       s_axis_tready,
	input wire logic [mqer_pkg::CMD_W-1:0] s_axis_tuser,
	input wire logic                       m_axis_tvalid,
	input wire logic                       m_axis_tready,
	input wire logic [((mqer_pkg::TYPE_W + PAYLOAD_BITS + 7) / 8) * 8 - 1:0]
	                                       m_axis_tdata
);
	import mqer_pkg::*;

	localparam int OUT_TD_W = ((TYPE_W + PAYLOAD_BITS + 7) / 8) * 8;

	logic res_none;
	logic req_real;

	assign res_none = m_axis_tvalid && m_axis_tdata[TYPE_W-1:0] == TYPE_NONE;
	assign req_real = s_axis_tvalid && s_axis_tready
	               && (s_axis_tuser == CMD_SCHED || s_axis_tuser == CMD_DEQ
	                   || s_axis_tuser == CMD_DRAIN);

	// a stalled result stays valid
	`MQER_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

	// a stalled result keeps its value
	`MQER_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))

	// an empty-queue result carries a zero payload and zero padding
	`MQER_ASSERT_SAME(a_none_zero, res_none, m_axis_tdata[OUT_TD_W-1:TYPE_W] == '0)

	// a real request keeps the block busy in the following cycle
	`MQER_ASSERT_NEXT(a_busy_after_req, req_real, !s_axis_tready)

endmodule

bind multi_queue_event_router_unit mqer_checker #(
	.PAYLOAD_BITS (PAYLOAD_BITS)
) u_mqer_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

[dv/multi_queue_event_router_unit_tb.sv]
`timescale 1ns / 1ps

module multi_queue_event_router_unit_tb;
	import mqer_pkg::*;

	localparam int SOURCES   = SOURCE_COUNT_DEF;
	localparam int RING_ROOM = QUEUE_DEPTH_DEF - 1;   // one slot always stays empty
	localparam int PAY_W     = PAYLOAD_BITS_DEF;
	localparam int S_DATA_W  = ((TYPE_W + PAY_W + SRC_W + 7) / 8) * 8;
	localparam int M_DATA_W  = ((TYPE_W + PAY_W + 7) / 8) * 8;
	localparam int CYCLE_LIMIT = 400000;

	// command code the block ignores
	localparam logic [CMD_W-1:0] CMD_IGNORED = 2'd3;

	// interrupt event types, one per source queue
	localparam logic [TYPE_W-1:0] TYPE_SP = 3'd1;
	localparam logic [TYPE_W-1:0] TYPE_DP = 3'd2;
	localparam logic [TYPE_W-1:0] TYPE_SI = 3'd3;
	localparam logic [TYPE_W-1:0] TYPE_VI = 3'd4;
	localparam logic [TYPE_W-1:0] TYPE_PI = 3'd5;
	localparam logic [TYPE_W-1:0] TYPE_AI = 3'd6;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [TYPE_W-1:0] kind;
		logic [PAY_W-1:0]  payload;
		logic [SRC_W-1:0]  src;
	} router_req_t;

	typedef struct packed {
		logic [TYPE_W-1:0] kind;
		logic [PAY_W-1:0]  payload;
	} event_rec_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [CMD_W-1:0] s_axis_tuser = '0;     // command
	logic [S_DATA_W-1:0] s_axis_tdata = '0;  // event_type, event_payload, interrupt_source, pad
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [M_DATA_W-1:0] m_axis_tdata;       // out_type, out_payload, pad

	// predictor state: one ring per interrupt source plus the main ring
	event_rec_t source_events [SOURCES][$];
	event_rec_t main_events[$];
	event_rec_t popped_events[$];            // expected dequeue results, oldest first

	router_req_t pending_reqs[$];
	router_req_t cur_req = '0;
	int unsigned issued_cnt = 0;
	int unsigned accepted_cnt = 0;
	int unsigned results_seen = 0;
	int unsigned mismatch_cnt = 0;
	int unsigned cycle_cnt = 0;

	multi_queue_event_router_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tuser(s_axis_tuser),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #5 clk = ~clk;

	// Append to the main ring; drop silently when it already holds its limit.
	function automatic void ring_push_main(event_rec_t rec);
		if (main_events.size() < RING_ROOM)
			main_events.push_back(rec);
	endfunction

	// Apply one accepted request to the predicted queue state.
	function automatic void route_request(router_req_t req);
		event_rec_t rec;
		rec.kind = req.kind;
		rec.payload = req.payload;
		case (req.cmd)
			CMD_SCHED: begin
				if (req.kind == TYPE_MAIN)
					ring_push_main(rec);
				else if (req.kind != TYPE_NONE && int'(req.kind) - 1 < SOURCES) begin
					if (source_events[req.kind - 1].size() < RING_ROOM)
						source_events[req.kind - 1].push_back(rec);
				end
			end
			CMD_DEQ: begin
				if (main_events.size() == 0)
					popped_events.push_back('{kind: TYPE_NONE, payload: '0});
				else
					popped_events.push_back(main_events.pop_front());
			end
			CMD_DRAIN: begin
				// move the whole source ring in order; overflow of main drops events
				if (int'(req.src) < SOURCES)
					while (source_events[req.src].size() > 0)
						ring_push_main(source_events[req.src].pop_front());
			end
			default: ;
		endcase
	endfunction

	function automatic router_req_t make_req(logic [CMD_W-1:0] cmd, logic [TYPE_W-1:0] kind,
			logic [PAY_W-1:0] payload, logic [SRC_W-1:0] src);
		router_req_t req;
		req.cmd = cmd;
		req.kind = kind;
		req.payload = payload;
		req.src = src;
		return req;
	endfunction

	// Sender: bursts of random length separated by random gaps.
	int burst_left = 0;
	int gap_left = 0;
	always @(negedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (s_axis_tvalid && accepted_cnt != issued_cnt) begin
			// hold the request until the block takes it
		end else begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			end
			if (gap_left > 0 || pending_reqs.size() == 0) begin
				if (gap_left > 0)
					gap_left = gap_left - 1;
				s_axis_tvalid <= 1'b0;
			end else begin
				cur_req = pending_reqs.pop_front();
				burst_left = burst_left - 1;
				issued_cnt = issued_cnt + 1;
				s_axis_tvalid <= 1'b1;
				s_axis_tuser <= cur_req.cmd;
				s_axis_tdata <= {{(S_DATA_W - TYPE_W - PAY_W - SRC_W){1'b0}},
					cur_req.src, cur_req.payload, cur_req.kind};
			end
		end
	end

	// Receiver: alternate clean and choppy stretches, plus one long hold-off
	// that backs the block up until it stops taking requests.
	int rx_phase_left = 0;
	bit rx_choppy = 1'b0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	always @(negedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (!hold_done && results_seen >= 150) begin
				hold_done = 1'b1;
				hold_left = 400;
			end
			if (rx_phase_left == 0) begin
				rx_phase_left = $urandom_range(10, 80);
				rx_choppy = ($urandom_range(0, 1) == 1);
			end
			rx_phase_left = rx_phase_left - 1;
			if (hold_left > 0) begin
				hold_left = hold_left - 1;
				m_axis_tready <= 1'b0;
			end else if (rx_choppy)
				m_axis_tready <= ($urandom_range(0, 9) < 6);
			else
				m_axis_tready <= 1'b1;
		end
	end

	// Predict on every request the block accepts.
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			route_request(cur_req);
			accepted_cnt <= accepted_cnt + 1;
		end
	end

	// Check every dequeue result against the oldest expectation.
	always @(posedge clk) begin
		event_rec_t want;
		logic [TYPE_W-1:0] got_kind;
		logic [PAY_W-1:0] got_payload;
		got_kind = m_axis_tdata[TYPE_W-1:0];
		got_payload = m_axis_tdata[TYPE_W +: PAY_W];
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen <= results_seen + 1;
			if (popped_events.size() == 0) begin
				$display("%0t: unexpected result type %0d payload %h", $time,
					got_kind, got_payload);
				mismatch_cnt <= mismatch_cnt + 1;
			end else begin
				want = popped_events.pop_front();
				if (got_kind != want.kind) begin
					$display("%0t: out_type expected %0d actual %0d", $time,
						want.kind, got_kind);
					mismatch_cnt <= mismatch_cnt + 1;
				end else if (got_payload != want.payload) begin
					// an empty-queue result carries a zero payload
					$display("%0t: out_payload expected %h actual %h", $time,
						want.payload, got_payload);
					mismatch_cnt <= mismatch_cnt + 1;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		int deq_weight;
		int focus_src;
		int pick;
		logic [CMD_W-1:0] cmd;
		logic [TYPE_W-1:0] kind;
		logic [SRC_W-1:0] src;

		// Directed: empty dequeue, every type with payload extremes, ignored
		// requests, a drain of every source index, then empty main again.
		pending_reqs.push_back(make_req(CMD_DEQ, TYPE_MAIN, 32'h0, 3'd0));
		pending_reqs.push_back(make_req(CMD_SCHED, TYPE_SP, 32'h0000_0000, 3'd0));
		pending_reqs.push_back(make_req(CMD_SCHED, TYPE_DP, 32'hffff_ffff, 3'd7));
		pending_reqs.push_back(make_req(CMD_SCHED, TYPE_SI, 32'ha5a5_a5a5, 3'd0));
		pending_reqs.push_back(make_req(CMD_SCHED, TYPE_VI, 32'h5a5a_5a5a, 3'd7));
		pending_reqs.push_back(make_req(CMD_SCHED, TYPE_PI, 32'h0000_0001, 3'd0));
		pending_reqs.push_back(make_req(CMD_SCHED, TYPE_AI, 32'h8000_0000, 3'd0));
		pending_reqs.push_back(make_req(CMD_SCHED, TYPE_MAIN, 32'hffff_ffff, 3'd0));
		pending_reqs.push_back(make_req(CMD_SCHED, TYPE_NONE, 32'h1234_5678, 3'd0));
		pending_reqs.push_back(make_req(CMD_IGNORED, TYPE_MAIN, 32'hffff_ffff, 3'd7));
		for (int s = 0; s < 8; s++)
			pending_reqs.push_back(make_req(CMD_DRAIN, TYPE_NONE, 32'h0, s[SRC_W-1:0]));
		for (int d = 0; d < 8; d++)
			pending_reqs.push_back(make_req(CMD_DEQ, TYPE_NONE, 32'h0, 3'd0));

		// Random: segments with their own dequeue rate and a favored source,
		// so rings fill, overflow, and drains spill past a full main ring.
		for (int seg = 0; seg < 16; seg++) begin
			deq_weight = $urandom_range(5, 45);
			focus_src = $urandom_range(0, SOURCES - 1);
			for (int n = 0; n < 100; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 3)
					cmd = CMD_IGNORED;
				else if (pick < 3 + deq_weight)
					cmd = CMD_DEQ;
				else if (pick < 18 + deq_weight)
					cmd = CMD_DRAIN;
				else
					cmd = CMD_SCHED;
				pick = $urandom_range(0, 99);
				if (pick < 55)
					kind = TYPE_SP + focus_src[TYPE_W-1:0];
				else if (pick < 95)
					kind = TYPE_W'($urandom_range(1, 7));
				else
					kind = TYPE_W'($urandom_range(0, 7));
				if ($urandom_range(0, 99) < 85)
					src = ($urandom_range(0, 1) == 0) ? focus_src[SRC_W-1:0]
						: SRC_W'($urandom_range(0, SOURCES - 1));
				else
					src = SRC_W'($urandom_range(0, 7));
				pending_reqs.push_back(make_req(cmd, kind, PAY_W'($urandom), src));
			end
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Wait for every request to go in, then for every result to come out.
		while (pending_reqs.size() > 0 || accepted_cnt != issued_cnt || s_axis_tvalid)
			@(posedge clk);
		while (popped_events.size() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		if (mismatch_cnt == 0 && popped_events.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
